@@ sv/utcs_pkg.sv @@
`timescale 1ns / 1ps
package utcs_pkg;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam int WORD_COUNT = 11;
   localparam logic [3:0] WORD_FLAGS = 4'd0;

   localparam int FLAG_USED = 0;
   localparam int FLAG_DISABLED = 1;
   localparam int FLAG_COLLIDABLE = 2;
   localparam int FLAG_KIND_LO = 3;

   localparam logic [1:0] KIND_CIRCLE = 2'd1;
   localparam logic [1:0] KIND_BOX = 2'd2;

   localparam logic signed [31:0] FX_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] FX_MIN = 32'sh8000_0000;

   // one slot: word 0 flags, then centre, height, radius, corner, axes
   typedef logic [WORD_COUNT-1:0][31:0] entry_type;

   typedef struct packed {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
      logic [30:0] size;
      logic corners;
      logic signed [31:0] e;
      logic [63:0] esq;
   } probe_type;

   function automatic logic signed [31:0] clamp33(input logic signed [32:0] s);
      if (s[32] != s[31]) begin
         return s[32] ? FX_MIN : FX_MAX;
      end
      return s[31:0];
   endfunction

   function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [32:0] s;
      s = {a[31], a} + {b[31], b};
      return clamp33(s);
   endfunction

   function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [32:0] s;
      s = {a[31], a} - {b[31], b};
      return clamp33(s);
   endfunction

   // product shifted down, rounding toward minus infinity
   function automatic logic signed [31:0] fmul(input logic signed [31:0] a,
                                               input logic signed [31:0] b,
                                               input int f);
      logic signed [63:0] p;
      logic signed [63:0] q;
      p = 64'(a) * 64'(b);
      q = p >>> f;
      if (q > 64'sh0000_0000_7FFF_FFFF) return FX_MAX;
      if (q < 64'shFFFF_FFFF_8000_0000) return FX_MIN;
      return q[31:0];
   endfunction

   function automatic logic signed [31:0] abs_sat(input logic signed [31:0] a);
      if (a == FX_MIN) return FX_MAX;
      return (a < 0) ? -a : a;
   endfunction

   function automatic logic [63:0] sq(input logic signed [31:0] a);
      logic signed [32:0] w;
      logic [32:0] m;
      w = {a[31], a};
      m = (w < 0) ? 33'(-w) : 33'(w);
      return 64'(m) * 64'(m);
   endfunction

endpackage

@@ sv/utcs_if.sv @@
`timescale 1ns / 1ps
interface utcs_req_if;
   logic valid;
   logic ready;
   logic command;
   logic [5:0] slot;
   logic [3:0] word_select;
   logic signed [31:0] word_value;
   logic signed [31:0] probe_x;
   logic signed [31:0] probe_y;
   logic signed [31:0] probe_z;
   logic [30:0] probe_size;
   logic search_kind;

   modport source(output valid, command, slot, word_select, word_value, probe_x,
                  probe_y, probe_z, probe_size, search_kind, input ready);
   modport sink(input valid, command, slot, word_select, word_value, probe_x,
                probe_y, probe_z, probe_size, search_kind, output ready);
endinterface

interface utcs_rsp_if;
   logic valid;
   logic ready;
   logic found;
   logic [5:0] hit_slot;

   modport source(output valid, found, hit_slot, input ready);
   modport sink(input valid, found, hit_slot, output ready);
endinterface

@@ sv/unit_table_collision_search_unit.sv @@
`timescale 1ns / 1ps
// Slot table with collision query. A write word loads one word of one slot and
// returns its (empty) result word from a register. A query word streams every
// slot out of the slot memory, one per cycle, through an eight-stage test
// pipeline and reports the lowest slot hit. Its result word is registered once
// the walk is over and the pipeline has drained. The next word can be taken in
// the same cycle as the result word leaves. Queries are taken one at a time.
module unit_table_collision_search_unit #(
   parameter int SLOT_COUNT = 64,
   parameter int FRACTION_BITS = 16
) (
   input logic clock,
   input logic reset,
   utcs_req_if.sink req,
   utcs_rsp_if.source rsp
);
   import utcs_pkg::*;

   localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam logic [AW-1:0] LAST_SLOT = AW'(SLOT_COUNT - 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PREP = 3'd1;
   localparam logic [2:0] ST_WALK = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_RESP = 3'd4;

   entry_type geom_mem [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] used_ff;

   logic [2:0] state_ff;
   logic [AW-1:0] cnt_ff;
   probe_type probe_ff;
   entry_type rd_ff;
   logic tag_valid_ff;
   logic [AW-1:0] tag_slot_ff;
   logic tag_used_ff;
   logic found_ff;
   logic [AW-1:0] found_slot_ff;
   logic rsp_valid_ff;
   logic rsp_found_ff;
   logic [5:0] rsp_slot_ff;

   logic accept;
   logic out_free;
   logic rsp_load;
   logic [8:0] wr_wide;
   logic [AW-1:0] wr_idx;
   logic [32:0] triple;
   logic hit_valid, hit, busy;
   logic [AW-1:0] hit_slot;
   logic [8:0] found_wide;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE) && out_free;
   assign accept = req.valid && req.ready;
   assign rsp_load = ((state_ff == ST_IDLE) && accept && (req.command == CMD_WRITE)) ||
                     ((state_ff == ST_RESP) && out_free);
   assign wr_wide = 9'(req.slot);
   assign wr_idx = wr_wide[AW-1:0];
   assign found_wide = 9'(found_slot_ff);
   // three times the probe size; halved into probe.e for 1.5 times, floor
   assign triple = {2'b00, req.probe_size} + {1'b0, req.probe_size, 1'b0};

   always_ff @(posedge clock) begin
      if (accept && req.command == CMD_WRITE && wr_wide < 9'(SLOT_COUNT) &&
          req.word_select < 4'(WORD_COUNT)) begin
         geom_mem[wr_idx][req.word_select] <= req.word_value;
      end
      rd_ff <= geom_mem[cnt_ff];
      tag_used_ff <= used_ff[cnt_ff];
      tag_slot_ff <= cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (accept && req.command == CMD_WRITE && wr_wide < 9'(SLOT_COUNT) &&
                   req.word_select == WORD_FLAGS) begin
         used_ff[wr_idx] <= req.word_value[FLAG_USED];
      end
   end

   utcs_test #(
      .ADDR_W(AW),
      .FRACTION_BITS(FRACTION_BITS)
   ) u_test (
      .clock(clock),
      .reset(reset),
      .tag_valid(tag_valid_ff),
      .tag_slot(tag_slot_ff),
      .tag_used(tag_used_ff),
      .entry(rd_ff),
      .probe(probe_ff),
      .hit_valid(hit_valid),
      .hit(hit),
      .hit_slot(hit_slot),
      .busy(busy)
   );

   always_ff @(posedge clock) begin
      if (accept && req.command == CMD_QUERY) begin
         probe_ff.px <= req.probe_x;
         probe_ff.py <= req.probe_y;
         probe_ff.pz <= req.probe_z;
         probe_ff.size <= req.probe_size;
         probe_ff.corners <= req.search_kind;
         probe_ff.e <= triple[32] ? FX_MAX : {1'b0, triple[31:1]};
      end
      if (state_ff == ST_PREP) begin
         probe_ff.esq <= sq(probe_ff.e);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         tag_valid_ff <= 1'b0;
         found_ff <= 1'b0;
         found_slot_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_found_ff <= 1'b0;
         rsp_slot_ff <= '0;
      end else begin
         tag_valid_ff <= (state_ff == ST_WALK);
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         // keep the lowest slot: hits leave the pipeline in slot order
         if (hit_valid && hit && !found_ff) begin
            found_ff <= 1'b1;
            found_slot_ff <= hit_slot;
         end
         unique case (state_ff)
            ST_IDLE: begin
               cnt_ff <= '0;
               if (accept) begin
                  if (req.command == CMD_WRITE) begin
                     rsp_found_ff <= 1'b0;
                     rsp_slot_ff <= '0;
                  end else begin
                     found_ff <= 1'b0;
                     found_slot_ff <= '0;
                     state_ff <= ST_PREP;
                  end
               end
            end
            ST_PREP: begin
               state_ff <= ST_WALK;
            end
            ST_WALK: begin
               cnt_ff <= (cnt_ff == LAST_SLOT) ? '0 : cnt_ff + 1'b1;
               if (cnt_ff == LAST_SLOT) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (!tag_valid_ff && !busy) begin
                  state_ff <= ST_RESP;
               end
            end
            ST_RESP: begin
               if (out_free) begin
                  rsp_found_ff <= found_ff;
                  rsp_slot_ff <= found_wide[5:0];
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.found = rsp_found_ff;
   assign rsp.hit_slot = rsp_slot_ff;

endmodule

@@ sv/utcs_test.sv @@
`timescale 1ns / 1ps
module utcs_test #(
   parameter int ADDR_W = 6,
   parameter int FRACTION_BITS = 16
) (
   input logic clock,
   input logic reset,
   input logic tag_valid,
   input logic [ADDR_W-1:0] tag_slot,
   input logic tag_used,
   input utcs_pkg::entry_type entry,
   input utcs_pkg::probe_type probe,
   output logic hit_valid,
   output logic hit,
   output logic [ADDR_W-1:0] hit_slot,
   output logic busy
);
   import utcs_pkg::*;

   localparam int STAGES = 8;
   localparam logic signed [31:0] NINE_TENTHS =
      32'(((64'sd9 <<< FRACTION_BITS) + 64'sd5) / 64'sd10);
   localparam logic signed [31:0] ONE_POINT_EIGHT =
      32'(((64'sd18 <<< FRACTION_BITS) + 64'sd5) / 64'sd10);

   typedef struct {
      logic valid;
      logic [ADDR_W-1:0] slot;
      logic elig;
      logic [1:0] kind;
      logic signed [31:0] cx, cy, cz, r, c, ax, az;
      logic signed [31:0] dx, dz, hm, bottom, top, rme, rc, lim;
      logic signed [31:0] m [8];
      logic signed [31:0] pa, pb, ux, uz, vx, vz, p, ap, nxm, nzm, nx, nz;
      logic signed [31:0] kx [4];
      logic signed [31:0] kz [4];
      logic signed [31:0] ex [4];
      logic signed [31:0] ez [4];
      logic [63:0] qx [4];
      logic [63:0] qz [4];
      logic signed [31:0] ddx, ddz;
      logic [63:0] sqdx, sqdz, sqlim, sqx, sqz, sqrc, sqc;
      logic limpos, band, circ, far, past, near, hit;
   } ctx_type;

   ctx_type stg_ff [STAGES];
   ctx_type stg_in [STAGES];

   logic signed [31:0] size_s;
   assign size_s = {1'b0, probe.size};

   // slot word fetched: differences, scaled height, band bottom, reach sums and corner products
   always_comb begin
      stg_in[0] = stg_ff[0];
      stg_in[0].valid = tag_valid;
      stg_in[0].slot = tag_slot;
      stg_in[0].kind = entry[WORD_FLAGS][FLAG_KIND_LO+1:FLAG_KIND_LO];
      stg_in[0].elig = tag_used && entry[WORD_FLAGS][FLAG_COLLIDABLE] &&
                       (entry[WORD_FLAGS][FLAG_KIND_LO+1:FLAG_KIND_LO] != 2'd0) &&
                       (probe.corners || !entry[WORD_FLAGS][FLAG_DISABLED]);
      stg_in[0].cx = entry[1];
      stg_in[0].cy = entry[2];
      stg_in[0].cz = entry[3];
      stg_in[0].r = entry[5];
      stg_in[0].c = entry[6];
      stg_in[0].ax = entry[7];
      stg_in[0].az = entry[8];
      stg_in[0].dx = sat_sub(probe.px, entry[1]);
      stg_in[0].dz = sat_sub(probe.pz, entry[3]);
      stg_in[0].hm = fmul(entry[4], NINE_TENTHS, FRACTION_BITS);
      stg_in[0].bottom = sat_sub(entry[2], ONE_POINT_EIGHT);
      stg_in[0].rme = sat_add(entry[5], probe.e);
      stg_in[0].rc = sat_add(entry[6], probe.e);
      stg_in[0].lim = sat_add(size_s, entry[5]);
      stg_in[0].m[0] = fmul(entry[5], entry[7], FRACTION_BITS);
      stg_in[0].m[1] = fmul(entry[6], entry[9], FRACTION_BITS);
      stg_in[0].m[2] = fmul(entry[5], entry[8], FRACTION_BITS);
      stg_in[0].m[3] = fmul(entry[6], entry[10], FRACTION_BITS);
      stg_in[0].m[4] = fmul(entry[6], entry[8], FRACTION_BITS);
      stg_in[0].m[5] = fmul(entry[5], entry[10], FRACTION_BITS);
      stg_in[0].m[6] = fmul(entry[6], entry[7], FRACTION_BITS);
      stg_in[0].m[7] = fmul(entry[5], entry[9], FRACTION_BITS);
   end

   always_comb begin
      stg_in[1] = stg_ff[0];
      stg_in[1].top = sat_add(stg_ff[0].cy, stg_ff[0].hm);
      stg_in[1].pa = fmul(stg_ff[0].dx, stg_ff[0].ax, FRACTION_BITS);
      stg_in[1].pb = fmul(stg_ff[0].dz, stg_ff[0].az, FRACTION_BITS);
      stg_in[1].ux = sat_add(stg_ff[0].m[0], stg_ff[0].m[1]);
      stg_in[1].uz = sat_add(stg_ff[0].m[2], stg_ff[0].m[3]);
      stg_in[1].vx = sat_add(stg_ff[0].m[4], stg_ff[0].m[5]);
      stg_in[1].vz = sat_add(stg_ff[0].m[6], stg_ff[0].m[7]);
      stg_in[1].sqdx = sq(stg_ff[0].dx);
      stg_in[1].sqdz = sq(stg_ff[0].dz);
      stg_in[1].sqlim = sq(stg_ff[0].lim);
      stg_in[1].limpos = stg_ff[0].lim > 0;
   end

   always_comb begin
      stg_in[2] = stg_ff[1];
      stg_in[2].band = !(stg_ff[1].top < probe.py || probe.py < stg_ff[1].bottom);
      stg_in[2].p = sat_add(stg_ff[1].pa, stg_ff[1].pb);
      stg_in[2].circ = stg_ff[1].limpos &&
                       (stg_ff[1].sqdx + stg_ff[1].sqdz < stg_ff[1].sqlim);
      stg_in[2].kx[0] = sat_add(stg_ff[1].cx, stg_ff[1].ux);
      stg_in[2].kz[0] = sat_add(stg_ff[1].cz, stg_ff[1].uz);
      stg_in[2].kx[1] = sat_sub(stg_ff[1].cx, stg_ff[1].vx);
      stg_in[2].kz[1] = sat_add(stg_ff[1].cz, stg_ff[1].vz);
      stg_in[2].kx[2] = sat_sub(stg_ff[1].cx, stg_ff[1].ux);
      stg_in[2].kz[2] = sat_sub(stg_ff[1].cz, stg_ff[1].uz);
      stg_in[2].kx[3] = sat_add(stg_ff[1].cx, stg_ff[1].vx);
      stg_in[2].kz[3] = sat_sub(stg_ff[1].cz, stg_ff[1].vz);
   end

   always_comb begin
      stg_in[3] = stg_ff[2];
      stg_in[3].ap = abs_sat(stg_ff[2].p);
      stg_in[3].nxm = fmul(stg_ff[2].p, stg_ff[2].ax, FRACTION_BITS);
      stg_in[3].nzm = fmul(stg_ff[2].p, stg_ff[2].az, FRACTION_BITS);
      for (int i = 0; i < 4; i++) begin
         stg_in[3].ex[i] = sat_sub(probe.px, stg_ff[2].kx[i]);
         stg_in[3].ez[i] = sat_sub(probe.pz, stg_ff[2].kz[i]);
      end
   end

   always_comb begin
      stg_in[4] = stg_ff[3];
      stg_in[4].nx = sat_add(stg_ff[3].nxm, stg_ff[3].cx);
      stg_in[4].nz = sat_add(stg_ff[3].nzm, stg_ff[3].cz);
      stg_in[4].far = stg_ff[3].rme < stg_ff[3].ap;
      stg_in[4].past = stg_ff[3].r < stg_ff[3].ap;
      for (int i = 0; i < 4; i++) begin
         stg_in[4].qx[i] = sq(stg_ff[3].ex[i]);
         stg_in[4].qz[i] = sq(stg_ff[3].ez[i]);
      end
   end

   always_comb begin
      stg_in[5] = stg_ff[4];
      stg_in[5].ddx = sat_sub(probe.px, stg_ff[4].nx);
      stg_in[5].ddz = sat_sub(probe.pz, stg_ff[4].nz);
      stg_in[5].near = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if (probe.e > 0 && (stg_ff[4].qx[i] + stg_ff[4].qz[i] < probe.esq)) begin
            stg_in[5].near = 1'b1;
         end
      end
   end

   always_comb begin
      stg_in[6] = stg_ff[5];
      stg_in[6].sqx = sq(stg_ff[5].ddx);
      stg_in[6].sqz = sq(stg_ff[5].ddz);
      stg_in[6].sqrc = sq(stg_ff[5].rc);
      stg_in[6].sqc = sq(stg_ff[5].c);
   end

   // final verdict: box needs in-reach, inside rounded radius, corner check
   always_comb begin
      logic [63:0] d2;
      logic box_hit;
      logic cap;
      stg_in[7] = stg_ff[6];
      d2 = stg_ff[6].sqx + stg_ff[6].sqz;
      cap = probe.corners && stg_ff[6].past && (stg_ff[6].sqc < d2);
      box_hit = !stg_ff[6].far && (d2 < stg_ff[6].sqrc) && (!cap || stg_ff[6].near);
      if (stg_ff[6].kind == KIND_CIRCLE) begin
         stg_in[7].hit = stg_ff[6].elig && stg_ff[6].band && stg_ff[6].circ;
      end else if (stg_ff[6].kind == KIND_BOX) begin
         stg_in[7].hit = stg_ff[6].elig && stg_ff[6].band && box_hit;
      end else begin
         stg_in[7].hit = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < STAGES; k++) begin
            stg_ff[k].valid <= 1'b0;
         end
      end else begin
         stg_ff <= stg_in;
      end
   end

   always_comb begin
      busy = 1'b0;
      for (int k = 0; k < STAGES; k++) begin
         busy = busy | stg_ff[k].valid;
      end
   end

   assign hit_valid = stg_ff[STAGES-1].valid;
   assign hit = stg_ff[STAGES-1].hit;
   assign hit_slot = stg_ff[STAGES-1].slot;

endmodule
